[rtl/core/cbc_pkg.sv]
// Shared types and constants for the cartridge bank controller.
// No dependencies; used by cbc_bank_regs and cartridge_bank_controller_core.
package cbc_pkg;

  localparam int RAM_BANK_COUNT_DEF = 4;
  localparam int ROM_BANK_BITS_DEF  = 7;
  localparam int RAM_BANK_BYTES     = 8192;
  localparam int RAM_INDEX_W        = 15;
  localparam int ROM_ADDR_W         = 21;

  // Address windows selected by bus_address[15:13].
  localparam logic [2:0] WIN_RAM_ENABLE = 3'b000;
  localparam logic [2:0] WIN_ROM_LOW    = 3'b001;
  localparam logic [2:0] WIN_BANK_HIGH  = 3'b010;
  localparam logic [2:0] WIN_MODE       = 3'b011;
  localparam logic [2:0] WIN_CART_RAM   = 3'b101;

  // Read windows selected by bus_address[15:14].
  localparam logic [1:0] WIN_ROM_FIXED  = 2'b00;
  localparam logic [1:0] WIN_ROM_BANKED = 2'b01;

  localparam logic REQ_READ  = 1'b0;
  localparam logic REQ_WRITE = 1'b1;

  typedef enum logic [2:0] {
    RGN_FIXED_ROM  = 3'd0,
    RGN_BANKED_ROM = 3'd1,
    RGN_RAM        = 3'd2,
    RGN_RAM_OFF    = 3'd3,
    RGN_OTHER      = 3'd4
  } region_t;

  typedef struct packed {
    region_t                  region;
    logic [ROM_ADDR_W-1:0]    rom_addr;
    logic                     ram_rd;
    logic                     ram_wr;
    logic [RAM_INDEX_W-1:0]   ram_index;
  } cbc_access_t;

endpackage

[rtl/core/cbc_bank_regs.sv]
// Bank control registers and access decode for the cartridge bank controller.
// Depends on cbc_pkg.
module cbc_bank_regs #(
  parameter int RAM_BANK_COUNT = cbc_pkg::RAM_BANK_COUNT_DEF,
  parameter int ROM_BANK_BITS  = cbc_pkg::ROM_BANK_BITS_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               upd,
  input  logic               req_type,
  input  logic [15:0]        bus_address,
  input  logic [7:0]         write_byte,
  output cbc_pkg::cbc_access_t acc
);

  logic [ROM_BANK_BITS-1:0] rom_bank, rom_bank_next;
  logic [1:0]               ram_bank, ram_bank_next;
  logic                     ram_banking_mode, ram_banking_mode_next;
  logic                     ram_enabled, ram_enabled_next;

  logic [6:0] rb_full;
  logic [6:0] rb_wide;
  logic [4:0] low5;
  logic [1:0] bank_eff;
  logic [2:0] win;

  assign rb_full = 7'(rom_bank);
  assign low5    = (write_byte[4:0] == 5'd0) ? 5'd1 : write_byte[4:0];
  assign win     = bus_address[15:13];

  // RAM bank wraps onto the banks that exist.
  always_comb begin
    if (RAM_BANK_COUNT == 1) begin
      bank_eff = 2'd0;
    end else if ({1'b0, ram_bank} >= 3'(RAM_BANK_COUNT)) begin
      bank_eff = 2'({1'b0, ram_bank} - 3'(RAM_BANK_COUNT));
    end else begin
      bank_eff = ram_bank;
    end
  end

  always_comb begin
    rom_bank_next         = rom_bank;
    ram_bank_next         = ram_bank;
    ram_banking_mode_next = ram_banking_mode;
    ram_enabled_next      = ram_enabled;
    rb_wide               = rb_full;
    if (req_type == cbc_pkg::REQ_WRITE) begin
      case (win)
        cbc_pkg::WIN_RAM_ENABLE: begin
          if (ram_banking_mode) begin
            ram_enabled_next = |(write_byte & 8'h0A);
          end
        end
        cbc_pkg::WIN_ROM_LOW: begin
          rb_wide       = {rb_full[6:5], low5};
          rom_bank_next = rb_wide[ROM_BANK_BITS-1:0];
        end
        cbc_pkg::WIN_BANK_HIGH: begin
          if (write_byte[1:0] != 2'd0) begin
            if (ram_banking_mode) begin
              ram_bank_next = write_byte[1:0];
            end else begin
              rb_wide       = {write_byte[1:0], rb_full[4:0]};
              rom_bank_next = rb_wide[ROM_BANK_BITS-1:0];
            end
          end
        end
        cbc_pkg::WIN_MODE: begin
          ram_banking_mode_next = write_byte[0];
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rom_bank         <= ROM_BANK_BITS'(1);
      ram_bank         <= 2'd0;
      ram_banking_mode <= 1'b0;
      ram_enabled      <= 1'b0;
    end else if (upd) begin
      rom_bank         <= rom_bank_next;
      ram_bank         <= ram_bank_next;
      ram_banking_mode <= ram_banking_mode_next;
      ram_enabled      <= ram_enabled_next;
    end
  end

  always_comb begin
    acc.region    = cbc_pkg::RGN_OTHER;
    acc.rom_addr  = '0;
    acc.ram_rd    = 1'b0;
    acc.ram_wr    = 1'b0;
    acc.ram_index = {bank_eff, bus_address[12:0]};
    if (win == cbc_pkg::WIN_CART_RAM) begin
      if (ram_enabled) begin
        acc.region = cbc_pkg::RGN_RAM;
        acc.ram_rd = (req_type == cbc_pkg::REQ_READ);
        acc.ram_wr = (req_type == cbc_pkg::REQ_WRITE);
      end else begin
        acc.region = cbc_pkg::RGN_RAM_OFF;
      end
    end else if (req_type == cbc_pkg::REQ_READ) begin
      if (bus_address[15:14] == cbc_pkg::WIN_ROM_FIXED) begin
        acc.region   = cbc_pkg::RGN_FIXED_ROM;
        acc.rom_addr = 21'(bus_address);
      end else if (bus_address[15:14] == cbc_pkg::WIN_ROM_BANKED) begin
        acc.region   = cbc_pkg::RGN_BANKED_ROM;
        acc.rom_addr = {rb_full, bus_address[13:0]};
      end
    end
  end

endmodule

[rtl/core/cartridge_bank_controller_core.sv]
// Cartridge bank controller: one bus access in, one result out per transfer.
// Accesses pass the s1 and output registers; throughput is one access per
// cycle while the output is not stalled, set by the single-port cartridge
// RAM (one read or one write per cycle) and the bank register update.
// Reset (synchronous, active high) restores ROM bank 1, RAM bank 0, ROM
// banking mode and RAM disabled; RAM contents are not cleared.
module cartridge_bank_controller_core #(
  parameter int RAM_BANK_COUNT = cbc_pkg::RAM_BANK_COUNT_DEF,
  parameter int ROM_BANK_BITS  = cbc_pkg::ROM_BANK_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [23:0] s_axis_tdata,  // [15:0] bus_address, [23:16] write_byte
  input  logic        s_axis_tuser,  // [0] req_type
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [31:0] m_axis_tdata,  // [7:0] read_byte, [28:8] rom_byte_address, zero pad
  output logic [2:0]  m_axis_tuser   // [2:0] region
);

  localparam int RAM_DEPTH = RAM_BANK_COUNT * cbc_pkg::RAM_BANK_BYTES;
  localparam int RAM_AW    = $clog2(RAM_DEPTH);

  cbc_pkg::cbc_access_t acc;

  logic accept;
  logic s1_adv;

  logic                              s1_valid;
  cbc_pkg::region_t                  s1_region;
  logic [cbc_pkg::ROM_ADDR_W-1:0]    s1_rom_addr;
  logic                              s1_ram_rd;

  logic                              out_valid;
  cbc_pkg::region_t                  out_region;
  logic [cbc_pkg::ROM_ADDR_W-1:0]    out_rom_addr;
  logic [7:0]                        out_byte;

  logic [7:0]        cart_ram [RAM_DEPTH];
  logic [7:0]        ram_q;
  logic [RAM_AW-1:0] ram_addr;

  cbc_bank_regs #(
    .RAM_BANK_COUNT(RAM_BANK_COUNT),
    .ROM_BANK_BITS (ROM_BANK_BITS)
  ) u_regs (
    .clk        (clk),
    .rst        (rst),
    .upd        (accept),
    .req_type   (s_axis_tuser),
    .bus_address(s_axis_tdata[15:0]),
    .write_byte (s_axis_tdata[23:16]),
    .acc        (acc)
  );

  assign s1_adv        = s1_valid && (!out_valid || m_axis_tready);
  assign s_axis_tready = !s1_valid || !out_valid || m_axis_tready;
  assign accept        = s_axis_tvalid && s_axis_tready;
  assign ram_addr      = acc.ram_index[RAM_AW-1:0];

  // The read data register only moves on a new read, so a stalled result
  // keeps its byte until it advances.
  always_ff @(posedge clk) begin
    if (accept && acc.ram_wr) begin
      cart_ram[ram_addr] <= s_axis_tdata[23:16];
    end
    if (accept && acc.ram_rd) begin
      ram_q <= cart_ram[ram_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (accept) begin
      s1_valid <= 1'b1;
    end else if (s1_adv) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_region   <= acc.region;
      s1_rom_addr <= acc.rom_addr;
      s1_ram_rd   <= acc.ram_rd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s1_adv) begin
      out_valid <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      out_region   <= s1_region;
      out_rom_addr <= s1_rom_addr;
      out_byte     <= s1_ram_rd ? ram_q : 8'd0;
    end
  end

  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = {3'd0, out_rom_addr, out_byte};
  assign m_axis_tuser  = out_region;

  a_ram_q_held: assert property (@(posedge clk) disable iff (rst)
    s1_valid && s1_ram_rd && !s1_adv |=> $stable(ram_q))
    else $error("RAM read data changed under a stalled read");

  a_byte_only_ram: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && (m_axis_tuser != cbc_pkg::RGN_RAM) |-> m_axis_tdata[7:0] == 8'd0)
    else $error("nonzero read byte outside a served RAM access");

  a_rom_addr_only_rom: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && (m_axis_tuser == cbc_pkg::RGN_RAM || m_axis_tuser == cbc_pkg::RGN_RAM_OFF
      || m_axis_tuser == cbc_pkg::RGN_OTHER) |-> m_axis_tdata[28:8] == 21'd0)
    else $error("ROM address reported outside a ROM read");

  a_no_drop: assert property (@(posedge clk) disable iff (rst)
    s1_valid && out_valid && !m_axis_tready |=> s1_valid && out_valid)
    else $error("pipeline lost an item while stalled");

endmodule
